FILE: src/bma_pkg.sv
// Package: buddy allocator types, constants and address helpers.
package bma_pkg;

  localparam int RegionLog = 10;
  localparam int NodeW     = RegionLog + 1;
  localparam int LvlW      = $clog2(RegionLog + 1);
  localparam int OwnW      = 8;
  localparam int ReqW      = 11;
  localparam int AddrW     = 10;
  localparam int SizeW     = 11;
  localparam int RegionSize = 1 << RegionLog;

  typedef enum logic [1:0] {
    ST_ABSENT = 2'd0,
    ST_FREE   = 2'd1,
    ST_USED   = 2'd2,
    ST_SPLIT  = 2'd3
  } node_st_e;

  typedef enum logic [1:0] {
    RES_OK      = 2'd0,
    RES_NOFIT   = 2'd1,
    RES_NOOWNER = 2'd2
  } res_e;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE,
    S_A_RD, S_A_EV, S_A_TAKE, S_A_SPL, S_A_RET,
    S_F_ERD, S_F_EEV, S_F_LRD, S_F_LEV, S_F_RRD, S_F_REV, S_F_RET,
    S_F_CO, S_F_CEV, S_F_W2, S_F_W3,
    S_DONE
  } state_e;

  typedef struct packed {
    logic             we;
    logic [NodeW-1:0] waddr;
    node_st_e         wstatus;
    logic             owner_we;
    logic [OwnW-1:0]  wowner;
    logic [NodeW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    node_st_e        status;
    logic [OwnW-1:0] owner;
  } mem_rsp_t;

  // Tree level whose block size is the request rounded up to a power of two.
  function automatic logic [LvlW-1:0] tgt_level(logic [ReqW-1:0] req);
    logic [LvlW-1:0] k;
    k = LvlW'(RegionLog);
    for (int i = RegionLog; i >= 0; i--) begin
      if ((ReqW+1)'(1) << i >= {1'b0, req}) k = LvlW'(i);
    end
    return LvlW'(RegionLog) - k;
  endfunction

  function automatic logic [AddrW-1:0] blk_start(logic [NodeW-1:0] node,
                                                logic [LvlW-1:0] lvl);
    logic [NodeW-1:0] off;
    off = node & ((NodeW'(1) << lvl) - NodeW'(1));
    return AddrW'(off << (LvlW'(RegionLog) - lvl));
  endfunction

  function automatic logic [SizeW-1:0] blk_size(logic [LvlW-1:0] lvl);
    return SizeW'(SizeW'(RegionSize) >> lvl);
  endfunction

endpackage

FILE: src/bma_node_mem.sv
// Node status and owner memories, one write and one registered read per cycle.
module bma_node_mem (
  input  logic              clk_i,
  input  bma_pkg::mem_req_t req_i,
  output bma_pkg::mem_rsp_t rsp_o
);

  localparam int Depth = 1 << bma_pkg::NodeW;

  bma_pkg::node_st_e           status_mem [Depth];
  logic [bma_pkg::OwnW-1:0]    owner_mem  [Depth];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      status_mem[req_i.waddr] <= req_i.wstatus;
    end
    if (req_i.owner_we) begin
      owner_mem[req_i.waddr] <= req_i.wowner;
    end
    rsp_o.status <= status_mem[req_i.raddr];
    rsp_o.owner  <= owner_mem[req_i.raddr];
  end

endmodule

FILE: src/buddy_memory_allocator_top.sv
// Top level: buddy allocator control walking a node memory.
//
// Input channel: action_i, request_size_i, owner_id_i with in_valid_i/in_stall_o.
// Output channel: status_o, start_address_o, block_size_o with out_valid_o/out_stall_i.
// A transaction is accepted when valid is high and stall is low.
// One item is processed at a time; every item yields exactly one result.
// The node tree sits in a memory with one write and one read port and a registered
// read, so each node visited takes an address state and an evaluate state.
// Allocate: a depth-first search reads and evaluates each node it visits and
// backtracks one level per step; a free block above the target level is split
// one level at a time, the right half marked free, down to the target level.
// Free: nodes are read and evaluated as a parent's child and on their own visit;
// each merge level reads the sibling; if it is free, both go absent, the parent free.
// After reset the status memory is swept, one node per cycle, over all 2048 nodes;
// in_stall_o stays high during the sweep.
// The result sits in an output register; the next transaction is accepted while
// it waits. If the receiver stalls, a finished result holds the block in its
// final state until the output register frees up.
module buddy_memory_allocator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [10:0] request_size_i,
  input  logic [7:0]  owner_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [9:0]  start_address_o,
  output logic [10:0] block_size_o
);

  localparam int NodeW = bma_pkg::NodeW;
  localparam int LvlW  = bma_pkg::LvlW;

  bma_pkg::state_e            state_q, state_d;
  logic [NodeW-1:0]           cur_q, cur_d;
  logic [LvlW-1:0]            lvl_q, lvl_d;
  logic [LvlW-1:0]            tl_q, tl_d;
  logic [bma_pkg::OwnW-1:0]   own_q, own_d;
  bma_pkg::res_e              res_q, res_d;
  logic [bma_pkg::AddrW-1:0]  rstart_q, rstart_d;
  logic [bma_pkg::SizeW-1:0]  rsize_q, rsize_d;
  logic                       ovalid_q, ovalid_d;
  bma_pkg::res_e              ostat_q;
  logic [bma_pkg::AddrW-1:0]  ostart_q;
  logic [bma_pkg::SizeW-1:0]  osize_q;

  bma_pkg::mem_req_t          mreq;
  bma_pkg::mem_rsp_t          mrsp;
  logic                       held;
  logic                       in_acc;
  logic                       out_free;
  logic [NodeW-1:0]           left_n, right_n, sib_n;

  bma_node_mem u_mem (
    .clk_i (clk_i),
    .req_i (mreq),
    .rsp_o (mrsp)
  );

  assign held     = (mrsp.status == bma_pkg::ST_USED) && (mrsp.owner == own_q);
  assign in_stall_o = (state_q != bma_pkg::S_IDLE);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !ovalid_q || !out_stall_i;
  assign left_n   = {cur_q[NodeW-2:0], 1'b0};
  assign right_n  = {cur_q[NodeW-2:0], 1'b1};
  assign sib_n    = cur_q ^ NodeW'(1);

  // next state and datapath
  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    lvl_d    = lvl_q;
    tl_d     = tl_q;
    own_d    = own_q;
    res_d    = res_q;
    rstart_d = rstart_q;
    rsize_d  = rsize_q;
    case (state_q)
      bma_pkg::S_CLR: begin
        cur_d = cur_q + NodeW'(1);
        if (&cur_q) state_d = bma_pkg::S_IDLE;
      end
      bma_pkg::S_IDLE: begin
        if (in_acc) begin
          cur_d    = NodeW'(1);
          lvl_d    = '0;
          own_d    = owner_id_i;
          tl_d     = bma_pkg::tgt_level(request_size_i);
          rstart_d = '0;
          rsize_d  = '0;
          if (action_i) begin
            state_d = bma_pkg::S_F_ERD;
          end else if (request_size_i > 11'(bma_pkg::RegionSize)) begin
            res_d   = bma_pkg::RES_NOFIT;
            state_d = bma_pkg::S_DONE;
          end else begin
            state_d = bma_pkg::S_A_RD;
          end
        end
      end
      bma_pkg::S_A_RD: state_d = bma_pkg::S_A_EV;
      bma_pkg::S_A_EV: begin
        if (mrsp.status == bma_pkg::ST_FREE) begin
          state_d = bma_pkg::S_A_TAKE;
        end else if (mrsp.status == bma_pkg::ST_SPLIT && lvl_q < tl_q) begin
          cur_d   = left_n;
          lvl_d   = lvl_q + LvlW'(1);
          state_d = bma_pkg::S_A_RD;
        end else begin
          state_d = bma_pkg::S_A_RET;
        end
      end
      bma_pkg::S_A_TAKE: begin
        if (lvl_q == tl_q) begin
          res_d    = bma_pkg::RES_OK;
          rstart_d = bma_pkg::blk_start(cur_q, lvl_q);
          rsize_d  = bma_pkg::blk_size(lvl_q);
          state_d  = bma_pkg::S_DONE;
        end else begin
          state_d = bma_pkg::S_A_SPL;
        end
      end
      bma_pkg::S_A_SPL: begin
        cur_d   = left_n;
        lvl_d   = lvl_q + LvlW'(1);
        state_d = bma_pkg::S_A_TAKE;
      end
      bma_pkg::S_A_RET: begin
        if (cur_q == NodeW'(1)) begin
          res_d   = bma_pkg::RES_NOFIT;
          state_d = bma_pkg::S_DONE;
        end else if (!cur_q[0]) begin
          cur_d   = sib_n;
          state_d = bma_pkg::S_A_RD;
        end else begin
          cur_d = cur_q >> 1;
          lvl_d = lvl_q - LvlW'(1);
        end
      end
      bma_pkg::S_F_ERD: state_d = bma_pkg::S_F_EEV;
      bma_pkg::S_F_EEV: begin
        if (held) begin
          res_d    = bma_pkg::RES_OK;
          rstart_d = bma_pkg::blk_start(cur_q, lvl_q);
          rsize_d  = bma_pkg::blk_size(lvl_q);
          state_d  = bma_pkg::S_F_CO;
        end else if (mrsp.status == bma_pkg::ST_SPLIT && lvl_q < LvlW'(bma_pkg::RegionLog)) begin
          state_d = bma_pkg::S_F_LRD;
        end else begin
          state_d = bma_pkg::S_F_RET;
        end
      end
      bma_pkg::S_F_LRD: state_d = bma_pkg::S_F_LEV;
      bma_pkg::S_F_LEV: begin
        if (held) begin
          cur_d    = left_n;
          lvl_d    = lvl_q + LvlW'(1);
          res_d    = bma_pkg::RES_OK;
          rstart_d = bma_pkg::blk_start(left_n, lvl_q + LvlW'(1));
          rsize_d  = bma_pkg::blk_size(lvl_q + LvlW'(1));
          state_d  = bma_pkg::S_F_CO;
        end else begin
          state_d = bma_pkg::S_F_RRD;
        end
      end
      bma_pkg::S_F_RRD: state_d = bma_pkg::S_F_REV;
      bma_pkg::S_F_REV: begin
        lvl_d = lvl_q + LvlW'(1);
        if (held) begin
          cur_d    = right_n;
          res_d    = bma_pkg::RES_OK;
          rstart_d = bma_pkg::blk_start(right_n, lvl_q + LvlW'(1));
          rsize_d  = bma_pkg::blk_size(lvl_q + LvlW'(1));
          state_d  = bma_pkg::S_F_CO;
        end else begin
          cur_d   = left_n;
          state_d = bma_pkg::S_F_ERD;
        end
      end
      bma_pkg::S_F_RET: begin
        if (cur_q == NodeW'(1)) begin
          res_d   = bma_pkg::RES_NOOWNER;
          state_d = bma_pkg::S_DONE;
        end else if (!cur_q[0]) begin
          cur_d   = sib_n;
          state_d = bma_pkg::S_F_ERD;
        end else begin
          cur_d = cur_q >> 1;
          lvl_d = lvl_q - LvlW'(1);
        end
      end
      bma_pkg::S_F_CO: begin
        if (cur_q == NodeW'(1)) state_d = bma_pkg::S_DONE;
        else                    state_d = bma_pkg::S_F_CEV;
      end
      bma_pkg::S_F_CEV: begin
        if (mrsp.status == bma_pkg::ST_FREE) state_d = bma_pkg::S_F_W2;
        else                                 state_d = bma_pkg::S_DONE;
      end
      bma_pkg::S_F_W2: state_d = bma_pkg::S_F_W3;
      bma_pkg::S_F_W3: begin
        cur_d   = cur_q >> 1;
        lvl_d   = lvl_q - LvlW'(1);
        state_d = bma_pkg::S_F_CO;
      end
      bma_pkg::S_DONE: begin
        if (out_free) state_d = bma_pkg::S_IDLE;
      end
      default: state_d = bma_pkg::S_IDLE;
    endcase
  end

  // memory requests and output load
  always_comb begin
    mreq          = '0;
    mreq.raddr    = cur_q;
    mreq.waddr    = cur_q;
    mreq.wstatus  = bma_pkg::ST_ABSENT;
    mreq.wowner   = own_q;
    ovalid_d      = ovalid_q && out_stall_i;
    case (state_q)
      bma_pkg::S_CLR: begin
        mreq.we      = 1'b1;
        mreq.wstatus = (cur_q == NodeW'(1)) ? bma_pkg::ST_FREE : bma_pkg::ST_ABSENT;
      end
      bma_pkg::S_A_TAKE: begin
        mreq.we = 1'b1;
        if (lvl_q == tl_q) begin
          mreq.wstatus  = bma_pkg::ST_USED;
          mreq.owner_we = 1'b1;
        end else begin
          mreq.wstatus = bma_pkg::ST_SPLIT;
        end
      end
      bma_pkg::S_A_SPL: begin
        mreq.we      = 1'b1;
        mreq.waddr   = right_n;
        mreq.wstatus = bma_pkg::ST_FREE;
      end
      bma_pkg::S_F_EEV: begin
        mreq.we      = held;
        mreq.wstatus = bma_pkg::ST_FREE;
      end
      bma_pkg::S_F_LRD: mreq.raddr = left_n;
      bma_pkg::S_F_LEV: begin
        mreq.we      = held;
        mreq.waddr   = left_n;
        mreq.wstatus = bma_pkg::ST_FREE;
      end
      bma_pkg::S_F_RRD: mreq.raddr = right_n;
      bma_pkg::S_F_REV: begin
        mreq.we      = held;
        mreq.waddr   = right_n;
        mreq.wstatus = bma_pkg::ST_FREE;
      end
      bma_pkg::S_F_CO: mreq.raddr = sib_n;
      bma_pkg::S_F_CEV: begin
        mreq.we      = (mrsp.status == bma_pkg::ST_FREE);
        mreq.wstatus = bma_pkg::ST_ABSENT;
      end
      bma_pkg::S_F_W2: begin
        mreq.we      = 1'b1;
        mreq.waddr   = sib_n;
        mreq.wstatus = bma_pkg::ST_ABSENT;
      end
      bma_pkg::S_F_W3: begin
        mreq.we      = 1'b1;
        mreq.waddr   = cur_q >> 1;
        mreq.wstatus = bma_pkg::ST_FREE;
      end
      bma_pkg::S_DONE: begin
        if (out_free) ovalid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bma_pkg::S_CLR;
      cur_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cur_q    <= cur_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q    <= lvl_d;
    tl_q     <= tl_d;
    own_q    <= own_d;
    res_q    <= res_d;
    rstart_q <= rstart_d;
    rsize_q  <= rsize_d;
    if (state_q == bma_pkg::S_DONE && out_free) begin
      ostat_q  <= res_q;
      ostart_q <= rstart_q;
      osize_q  <= rsize_q;
    end
  end

  assign out_valid_o     = ovalid_q;
  assign status_o        = ostat_q;
  assign start_address_o = ostart_q;
  assign block_size_o    = osize_q;

endmodule

FILE: src/bma_checker.sv
// Port-level checker for the buddy allocator, bound to the top level.
module bma_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [9:0]  start_address_o,
  input logic [10:0] block_size_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped under stall");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != bma_pkg::RES_OK |->
      start_address_o == '0 && block_size_o == '0)
    else $error("failed transaction carries address or size");

  a_size_pow2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == bma_pkg::RES_OK |-> $onehot(block_size_o))
    else $error("block size not a power of two");

  a_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == bma_pkg::RES_OK |->
      ({1'b0, start_address_o} & (block_size_o - 11'd1)) == 11'd0)
    else $error("block start not aligned to its size");

endmodule

bind buddy_memory_allocator_top bma_port_checker u_bma_port_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_o        (status_o),
  .start_address_o (start_address_o),
  .block_size_o    (block_size_o)
);
